### sv/vector_soft_threshold_shrink_assert.svh
// assertion macros for the vector soft threshold shrink block
`ifndef VECTOR_SOFT_THRESHOLD_SHRINK_ASSERT_SVH
`define VECTOR_SOFT_THRESHOLD_SHRINK_ASSERT_SVH
// implication checked while out of reset
`define VSTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked during reset too
`define VSTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

### sv/vsts_pkg.sv
// shared types and constants for the vector soft threshold shrink block
package vsts_pkg;
  localparam int MAX_COMPONENTS_DEF = 3;
  localparam int NUM_FIELDS = 3;
  localparam int ROOT_BITS = 32;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_COMPONENTS_USED = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic [NUM_FIELDS-1:0][31:0] mag;
    logic [NUM_FIELDS-1:0] neg;
  } vec_t;

  typedef struct packed {
    logic [63:0] x;
    logic [32:0] rem;
    logic [31:0] root;
    vec_t v;
  } sq_t;

  typedef struct packed {
    logic [31:0] d;
    logic zeroed;
    logic [NUM_FIELDS-1:0] neg;
    logic [NUM_FIELDS-1:0][32:0] rem;
    logic [NUM_FIELDS-1:0][31:0] num;
  } dv_t;
endpackage

### sv/vsts_in_if.sv
// input channel carrying one gradient vector
interface vsts_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] comp_a;
  logic signed [31:0] comp_b;
  logic signed [31:0] comp_c;
  modport source (output valid, comp_a, comp_b, comp_c, input ready);
  modport sink (input valid, comp_a, comp_b, comp_c, output ready);
endinterface

### sv/vsts_out_if.sv
// result channel carrying one shrunk vector
interface vsts_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] shrunk_a;
  logic signed [31:0] shrunk_b;
  logic signed [31:0] shrunk_c;
  logic zeroed;
  modport source (output valid, shrunk_a, shrunk_b, shrunk_c, zeroed, input ready);
  modport sink (input valid, shrunk_a, shrunk_b, shrunk_c, zeroed, output ready);
endinterface

### sv/vsts_cfg_if.sv
// configuration write channel
interface vsts_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/vector_soft_threshold_shrink.sv
// top level of the vector soft threshold shrink block
// throughput: one vector per cycle while the result is not stalled, set by the 32 root cells and 32 divider cells
// every cell moves on together; a stalled result holds the whole chain
// reset: synchronous active-low rst_n clears valid bits, threshold 65536, two components
`include "vector_soft_threshold_shrink_assert.svh"
module vector_soft_threshold_shrink import vsts_pkg::*; #(
  parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
  input logic clk,
  input logic rst_n,
  vsts_in_if.sink    in_port,
  vsts_out_if.source out_port,
  vsts_cfg_if.sink   cfg_port
);
  // effective component limit, never more than the input fields
  localparam int LIM = (MAX_COMPONENTS < NUM_FIELDS) ? MAX_COMPONENTS : NUM_FIELDS;
  localparam logic [1:0] LIM_C = 2'(LIM);

  logic [30:0] thr_r;
  logic [1:0] used_r;
  logic en;

  // configuration registers, always ready
  assign cfg_port.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 31'd65536;
      used_r <= 2'd2;
    end else if (cfg_port.valid) begin
      unique case (cfg_port.index)
        REG_THRESHOLD:       thr_r <= cfg_port.data[30:0];
        REG_COMPONENTS_USED: used_r <= cfg_port.data[1:0];
        default: ;
      endcase
    end
  end

  // chain advances whenever the output register is free or being drained
  logic out_vld_r;
  assign en = !out_vld_r || out_port.ready;
  assign in_port.ready = en;

  // stage: magnitudes, masked by the components in use
  logic [1:0] used_eff;
  logic [NUM_FIELDS-1:0][31:0] comp_in;
  vec_t vin_nxt, vin_r;
  logic vin_vld_r;
  assign used_eff = (used_r > LIM_C) ? LIM_C : used_r;
  assign comp_in = {in_port.comp_c, in_port.comp_b, in_port.comp_a};
  always_comb begin
    for (int k = 0; k < NUM_FIELDS; k++) begin
      if (2'(k) < used_eff) begin
        vin_nxt.neg[k] = comp_in[k][31];
        vin_nxt.mag[k] = comp_in[k][31] ? 32'(-comp_in[k]) : comp_in[k];
      end else begin
        vin_nxt.neg[k] = 1'b0;
        vin_nxt.mag[k] = '0;
      end
    end
  end

  // stage: squares
  logic [NUM_FIELDS-1:0][63:0] sq_r;
  vec_t vsq_r;
  logic vsq_vld_r;

  // stage: sum of squares enters the root chain
  sq_t root_in_r;
  logic root_in_vld_r;

  logic [ROOT_BITS:0] rc_vld;
  sq_t rc_dat [ROOT_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vin_vld_r <= 1'b0;
      vsq_vld_r <= 1'b0;
      root_in_vld_r <= 1'b0;
    end else if (en) begin
      vin_vld_r <= in_port.valid;
      vsq_vld_r <= vin_vld_r;
      root_in_vld_r <= vsq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vin_r <= vin_nxt;
      for (int k = 0; k < NUM_FIELDS; k++) begin
        sq_r[k] <= vin_r.mag[k] * vin_r.mag[k];
      end
      vsq_r <= vin_r;
      // three squares of at most 2^62 each cannot carry out of 64 bits
      root_in_r.x <= sq_r[0] + sq_r[1] + sq_r[2];
      root_in_r.rem <= '0;
      root_in_r.root <= '0;
      root_in_r.v <= vsq_r;
    end
  end

  // root chain: one result bit per cell
  assign rc_vld[0] = root_in_vld_r;
  assign rc_dat[0] = root_in_r;
  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_root
    vsts_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(rc_vld[i]), .dat_i(rc_dat[i]),
      .vld_o(rc_vld[i+1]), .dat_o(rc_dat[i+1])
    );
  end

  // stage: compare norm against threshold and form norm - threshold
  logic [31:0] norm_r, diff_r;
  logic zero_r, cmp_vld_r;
  vec_t vcmp_r;
  logic [31:0] norm_w;
  assign norm_w = rc_dat[ROOT_BITS].root;

  // stage: products enter the divider chain
  dv_t div_in_r;
  logic div_in_vld_r;
  logic [NUM_FIELDS-1:0][63:0] prod;

  always_comb begin
    for (int k = 0; k < NUM_FIELDS; k++) begin
      prod[k] = vcmp_r.mag[k] * diff_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
      div_in_vld_r <= 1'b0;
    end else if (en) begin
      cmp_vld_r <= rc_vld[ROOT_BITS];
      div_in_vld_r <= cmp_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm_r <= norm_w;
      zero_r <= norm_w <= {1'b0, thr_r};
      diff_r <= norm_w - {1'b0, thr_r};
      vcmp_r <= rc_dat[ROOT_BITS].v;
      // quotient fits 32 bits since each magnitude is at most the norm
      div_in_r.d <= norm_r;
      div_in_r.zeroed <= zero_r;
      div_in_r.neg <= vcmp_r.neg;
      for (int k = 0; k < NUM_FIELDS; k++) begin
        div_in_r.rem[k] <= {1'b0, prod[k][63:32]};
        div_in_r.num[k] <= prod[k][31:0];
      end
    end
  end

  // divider chain: one quotient bit per cell, three lanes side by side
  logic [31:0] dc_vld;
  dv_t dc_dat [33];
  logic dc_last_vld;
  for (genvar i = 0; i < 32; i++) begin : g_div
    if (i == 0) begin : g_first
      vsts_div_cell u_cell (
        .clk(clk), .rst_n(rst_n), .en(en),
        .vld_i(div_in_vld_r), .dat_i(dc_dat[0]),
        .vld_o(dc_vld[0]), .dat_o(dc_dat[1])
      );
    end else begin : g_rest
      vsts_div_cell u_cell (
        .clk(clk), .rst_n(rst_n), .en(en),
        .vld_i(dc_vld[i-1]), .dat_i(dc_dat[i]),
        .vld_o(dc_vld[i]), .dat_o(dc_dat[i+1])
      );
    end
  end
  assign dc_dat[0] = div_in_r;
  assign dc_last_vld = dc_vld[31];

  // output register: restore signs, force zero at or below threshold
  logic [NUM_FIELDS-1:0][31:0] res_nxt, res_r;
  logic zeroed_r;
  dv_t dlast;
  assign dlast = dc_dat[32];
  always_comb begin
    for (int k = 0; k < NUM_FIELDS; k++) begin
      if (dlast.zeroed) begin
        res_nxt[k] = '0;
      end else if (dlast.neg[k]) begin
        res_nxt[k] = 32'(-dlast.num[k]);
      end else begin
        res_nxt[k] = dlast.num[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dc_last_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      zeroed_r <= dlast.zeroed;
    end
  end

  assign out_port.valid = out_vld_r;
  assign out_port.shrunk_a = res_r[0];
  assign out_port.shrunk_b = res_r[1];
  assign out_port.shrunk_c = res_r[2];
  assign out_port.zeroed = zeroed_r;

  // a zeroed result carries only zero components
  `VSTS_ASSERT_IMP(a_zeroed_clear, out_vld_r && zeroed_r, res_r == '0, "zeroed result not clear")
  // nothing comes out of the chain right after reset
  `VSTS_ASSERT_NEXT(a_reset_idle, !rst_n, !out_port.valid && !dc_last_vld, "valid after reset")
endmodule

### sv/vsts_sqrt_cell.sv
// one digit cell of the pipelined integer square root
module vsts_sqrt_cell import vsts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  sq_t  dat_i,
  output logic vld_o,
  output sq_t  dat_o
);
  logic vld_r;
  sq_t dat_r, dat_nxt;
  logic [34:0] rem_sh, trial;

  always_comb begin
    rem_sh = {dat_i.rem, dat_i.x[63:62]};
    trial = {1'b0, dat_i.root, 2'b01};
    dat_nxt = dat_i;
    dat_nxt.x = {dat_i.x[61:0], 2'b00};
    if (rem_sh >= trial) begin
      dat_nxt.rem = 33'(rem_sh - trial);
      dat_nxt.root = {dat_i.root[30:0], 1'b1};
    end else begin
      dat_nxt.rem = rem_sh[32:0];
      dat_nxt.root = {dat_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;
endmodule

### sv/vsts_div_cell.sv
// one quotient-bit cell of the pipelined three-lane divider
module vsts_div_cell import vsts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  dv_t  dat_i,
  output logic vld_o,
  output dv_t  dat_o
);
  logic vld_r;
  dv_t dat_r, dat_nxt;
  logic [NUM_FIELDS-1:0][32:0] rem_sh;

  always_comb begin
    dat_nxt = dat_i;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      rem_sh[k] = {dat_i.rem[k][31:0], dat_i.num[k][31]};
      if (rem_sh[k] >= {1'b0, dat_i.d}) begin
        dat_nxt.rem[k] = rem_sh[k] - {1'b0, dat_i.d};
        dat_nxt.num[k] = {dat_i.num[k][30:0], 1'b1};
      end else begin
        dat_nxt.rem[k] = rem_sh[k];
        dat_nxt.num[k] = {dat_i.num[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;
endmodule

### verif/vsts_checker.sv
`timescale 1ns / 100ps
// checker that predicts shrunk vectors and compares them with the block's results
module vsts_checker import vsts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  vsts_in_if.sink    in_mon,
  vsts_out_if.sink   out_mon,
  vsts_cfg_if.sink   cfg_mon,
  output int         fail_count,
  output int         pending_count
);
  typedef struct packed {
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    logic signed [31:0] sc;
    logic zeroed;
  } shrunk_t;

  shrunk_t shrunk_q[$];
  logic [30:0] thr;
  logic [1:0] used_cnt;

  function automatic logic [63:0] int_root(input logic [63:0] x);
    logic [63:0] rem, res, b;
    rem = x;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic shrunk_t shrink_vec(input logic [31:0] c0, input logic [31:0] c1,
                                         input logic [31:0] c2);
    logic [31:0] comp[3];
    logic [31:0] mag[3];
    logic [31:0] res[3];
    logic [63:0] sum, nrm, r;
    int n;
    shrunk_t s;
    comp[0] = c0;
    comp[1] = c1;
    comp[2] = c2;
    n = used_cnt;
    if (n > 3) n = 3;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = comp[k][31] ? -comp[k] : comp[k];
      res[k] = 0;
    end
    for (int k = 0; k < n; k++) sum += 64'(mag[k]) * 64'(mag[k]);
    nrm = int_root(sum);
    s.zeroed = (nrm <= 64'(thr));
    if (!s.zeroed) begin
      for (int k = 0; k < n; k++) begin
        r = (64'(mag[k]) * (nrm - 64'(thr))) / nrm;
        res[k] = comp[k][31] ? -r[31:0] : r[31:0];
      end
    end
    s.sa = res[0];
    s.sb = res[1];
    s.sc = res[2];
    return s;
  endfunction

  assign pending_count = shrunk_q.size();

  always @(posedge clk) begin
    shrunk_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      thr <= 31'd65536;
      used_cnt <= 2'd2;
      fail_count <= 0;
      shrunk_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (shrunk_q.size() == 0) begin
          $error("unexpected result transaction");
          errs = errs + 1;
        end else begin
          e = shrunk_q.pop_front();
          if (out_mon.shrunk_a !== e.sa) begin
            $error("shrunk_a expected %0d actual %0d", e.sa, out_mon.shrunk_a);
            errs = errs + 1;
          end
          if (out_mon.shrunk_b !== e.sb) begin
            $error("shrunk_b expected %0d actual %0d", e.sb, out_mon.shrunk_b);
            errs = errs + 1;
          end
          if (out_mon.shrunk_c !== e.sc) begin
            $error("shrunk_c expected %0d actual %0d", e.sc, out_mon.shrunk_c);
            errs = errs + 1;
          end
          if (out_mon.zeroed !== e.zeroed) begin
            $error("zeroed expected %0d actual %0d", e.zeroed, out_mon.zeroed);
            errs = errs + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        shrunk_q = {shrunk_q, shrink_vec(in_mon.comp_a, in_mon.comp_b, in_mon.comp_c)};
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_THRESHOLD) thr <= cfg_mon.data[30:0];
        else if (cfg_mon.index == REG_COMPONENTS_USED) used_cnt <= cfg_mon.data[1:0];
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// top of the testbench for the vector soft threshold shrink block
module testbench;
  import vsts_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int fail_count;
  int pending_count;
  bit in_calm, out_calm;   // stretches with no idling

  vsts_in_if  in_ch();
  vsts_out_if out_ch();
  vsts_cfg_if cfg_ch();

  vector_soft_threshold_shrink dut (
    .clk(clk), .rst_n(rst_n),
    .in_port(in_ch.sink), .out_port(out_ch.source), .cfg_port(cfg_ch.sink)
  );

  vsts_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_mon(in_ch.sink), .out_mon(out_ch.sink), .cfg_mon(cfg_ch.sink),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always #6 clk = ~clk;

  // hard limit on the run, far above the slowest correct run
  initial begin
    #30ms;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.comp_a = '0;
    in_ch.comp_b = '0;
    in_ch.comp_c = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_THRESHOLD;
    cfg_ch.data = '0;
  end

  // receiver stalls at random, with a chance of about 21 in a hundred, except in calm stretches
  always @(posedge clk) begin
    out_ch.ready <= out_calm || ($urandom_range(99) >= 21);
  end

  // write one register, waiting for the handshake
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // send one vector, with a random idle gap before it
  task automatic send_vec(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    while (!in_calm && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.comp_a <= a;
    in_ch.comp_b <= b;
    in_ch.comp_c <= c;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // let the pipeline drain before a config write
  task automatic drain();
    end_burst();
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // random component: full range, small values, extremes, or shifted small values
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(65536 * 4)) - 131072);
      2: return 32'($signed($urandom_range(65536 * 64)) - 2097152);
      3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(2000)) - 1000) <<< $urandom_range(20);
    endcase
  endfunction

  logic [31:0] thr_set[6] = '{32'd0, 32'd65536, 32'h7fff_ffff, 32'd1, 32'hffff_ffff, 32'd300000};

  initial begin
    in_calm = 1'b0;
    out_calm = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config first, extremes and special cases
    send_vec(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vec(32'd0, 32'd0, 32'd0);
    send_vec(32'd65536, 32'd0, 32'd5);           // norm equal to threshold
    send_vec(32'd65537, 32'd0, 32'd0);           // just over threshold
    send_vec(-32'sd200000, 32'd150000, 32'd9);
    drain();
    // zero components in use
    write_reg(REG_COMPONENTS_USED, 32'd0);
    send_vec(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
    send_vec(32'd1, 32'd1, 32'd1);
    drain();
    // zero threshold, all three used: passthrough
    write_reg(REG_COMPONENTS_USED, 32'd3);
    write_reg(REG_THRESHOLD, 32'd0);
    send_vec(32'd0, 32'd0, 32'd0);
    send_vec(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_vec(-32'sd1, 32'd1, -32'sd7);
    drain();
    // maximum threshold
    write_reg(REG_THRESHOLD, 32'hffff_ffff);
    send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    drain();
    write_reg(REG_COMPONENTS_USED, 32'd1);
    write_reg(REG_THRESHOLD, 32'd1);
    send_vec(-32'sd2, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vec(32'h8000_0000, 32'd3, 32'd3);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_COMPONENTS_USED, ph % 4 == 0 ? $urandom : ph % 4);
      write_reg(REG_THRESHOLD, ph < 6 ? thr_set[ph] : $urandom_range(1 << 22));
      in_calm = (ph == 4);
      out_calm = (ph == 4);
      for (int i = 0; i < 125; i++) send_vec(rand_comp(), rand_comp(), rand_comp());
      drain();   // sender holds off until all results are back
    end
    in_calm = 1'b0;
    out_calm = 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
